// File: hw/rtl/ncrt_pkg.sv
// Shared constants, codes and control types for the NACK chunk receive tracker.
`default_nettype none
package ncrt_pkg;

  localparam int CHUNK_CAPACITY_DEF = 4096;
  localparam int FILE_CAPACITY_DEF  = 256;
  localparam int MAX_NACKS_DEF      = 6;

  localparam logic [15:0] FILES_EXPECTED_RST = 16'd3;

  // packet types
  localparam logic [1:0] CMD_INFO = 2'd0;
  localparam logic [1:0] CMD_DATA = 2'd1;

  // status outcomes
  localparam logic [2:0] OC_STORED    = 3'd0;
  localparam logic [2:0] OC_DUPLICATE = 3'd1;
  localparam logic [2:0] OC_INFO      = 3'd2;
  localparam logic [2:0] OC_OTHER     = 3'd3;
  localparam logic [2:0] OC_RANGE     = 3'd4;
  localparam logic [2:0] OC_FILE_DONE = 3'd5;
  localparam logic [2:0] OC_REDUNDANT = 3'd6;
  localparam logic [2:0] OC_BAD_CSUM  = 3'd7;

  localparam logic KIND_NACK   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic decide;
    logic clr_wr;
    logic fclr;
    logic ptr_clr;
    logic ptr_inc;
    logic mark_rd;
    logic mark_wr;
    logic scan_rd;
    logic nack_load;
    logic nack_emit;
    logic done_chk;
    logic finish;
    logic stat_emit;
  } ncrt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic dec_clear;
    logic dec_proc;
    logic proc_q;
    logic clr_last;
    logic rclr_last;
    logic nack_end;
    logic word_done;
    logic done_end;
    logic word_full;
    logic out_free;
  } ncrt_stat_t;

endpackage
`default_nettype wire

// File: hw/rtl/nack_chunk_receive_tracker.sv
// Top level of the NACK-based multicast receive tracker.
`default_nettype none
//
//  channel  dir  handshake          payload
//  -------  ---  -----------------  ---------------------------------------------
//  s_*      in   s_tvalid/s_tready  one decoded packet header per item
//  m_*      out  m_tvalid/m_tready  NACK items, then one status item (m_tlast)
//
// Every header is captured, then decoded in the following cycle against the finished-file
// RAM. Non-data packets go straight from decode to their status item. A good data
// packet reads and rewrites its bitmap word; the gap scan then reads 64-bit bitmap
// words up to the highest chunk and emits a NACK per missing chunk, MAX_NACKS at most;
// the completion scan reads words up to the expected total, ~64 words at 4096 chunks.
// A packet for a new file first sweeps the bitmap clear, one word a cycle (64 words).
// After reset a sweep clears bitmap and finished-file RAM (256 entries by default)
// before s_tready rises. A stalled m_tready holds the block; nothing is dropped.
module nack_chunk_receive_tracker #(
  parameter int CHUNK_CAPACITY = ncrt_pkg::CHUNK_CAPACITY_DEF,
  parameter int FILE_CAPACITY  = ncrt_pkg::FILE_CAPACITY_DEF,
  parameter int MAX_NACKS      = ncrt_pkg::MAX_NACKS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [15:0] file_ident, [31:16] chunk_number, [47:32] chunk_total, [48] checksum_ok
  input  wire logic [55:0] s_tdata,
  // [1:0] cmd
  input  wire logic [1:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [11:0] nack_chunk, [19:12] nack_file, [22:20] outcome, [23] file_complete,
  // [24] all_files_received
  output logic [31:0]      m_tdata,
  // [0] kind
  output logic [0:0]       m_tuser,
  output logic             m_tlast
);
  import ncrt_pkg::*;

  ncrt_cmd_t  cmd;
  ncrt_stat_t st;

  logic        o_kind, o_fc, o_all;
  logic [11:0] o_chunk;
  logic [7:0]  o_file;
  logic [2:0]  o_outcome;

  ncrt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  ncrt_dp #(
    .CHUNK_CAPACITY (CHUNK_CAPACITY),
    .FILE_CAPACITY  (FILE_CAPACITY),
    .MAX_NACKS      (MAX_NACKS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .in_cmd      (s_tuser),
    .in_file     (s_tdata[15:0]),
    .in_chunk    (s_tdata[31:16]),
    .in_total    (s_tdata[47:32]),
    .in_csok     (s_tdata[48]),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_kind    (o_kind),
    .out_chunk   (o_chunk),
    .out_file    (o_file),
    .out_outcome (o_outcome),
    .out_fc      (o_fc),
    .out_all     (o_all),
    .out_last    (m_tlast)
  );

  // pack the result fields, zero-fill to 32 bits
  assign m_tdata    = {7'd0, o_all, o_fc, o_outcome, o_file, o_chunk};
  assign m_tuser[0] = o_kind;

endmodule
`default_nettype wire

// File: hw/rtl/ncrt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module ncrt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/ncrt_ctrl.sv
// Sequencer for the tracker: clear sweeps, mark, NACK scan, completion scan, status.
`default_nettype none
module ncrt_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire ncrt_pkg::ncrt_stat_t st,
  output ncrt_pkg::ncrt_cmd_t     cmd
);
  import ncrt_pkg::*;

  localparam logic [3:0] S_RCLR = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_CLR  = 4'd2;
  localparam logic [3:0] S_MRD  = 4'd3;
  localparam logic [3:0] S_MWT  = 4'd4;
  localparam logic [3:0] S_NRD  = 4'd5;
  localparam logic [3:0] S_NWT  = 4'd6;
  localparam logic [3:0] S_NEM  = 4'd7;
  localparam logic [3:0] S_DRD  = 4'd8;
  localparam logic [3:0] S_DWT  = 4'd9;
  localparam logic [3:0] S_DFIN = 4'd10;
  localparam logic [3:0] S_STAT = 4'd11;
  localparam logic [3:0] S_DEC  = 4'd12;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RCLR;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_RCLR: begin
        cmd.clr_wr = 1'b1;
        cmd.fclr = 1'b1;
        cmd.ptr_inc = 1'b1;
        if (st.rclr_last) begin
          cmd.ptr_clr = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        cmd.decide = 1'b1;
        cmd.ptr_clr = 1'b1;
        if (st.dec_clear) state_next = S_CLR;
        else if (st.dec_proc) state_next = S_MRD;
        else state_next = S_STAT;
      end
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        cmd.ptr_inc = 1'b1;
        if (st.clr_last) begin
          cmd.ptr_clr = 1'b1;
          state_next = st.proc_q ? S_MRD : S_STAT;
        end
      end
      S_MRD: begin
        cmd.mark_rd = 1'b1;
        state_next = S_MWT;
      end
      S_MWT: begin
        cmd.mark_wr = 1'b1;
        cmd.ptr_clr = 1'b1;
        state_next = S_NRD;
      end
      S_NRD: begin
        if (st.nack_end) begin
          cmd.ptr_clr = 1'b1;
          state_next = S_DRD;
        end else begin
          cmd.scan_rd = 1'b1;
          state_next = S_NWT;
        end
      end
      S_NWT: begin
        cmd.nack_load = 1'b1;
        state_next = S_NEM;
      end
      S_NEM: begin
        if (st.word_done) begin
          cmd.ptr_inc = 1'b1;
          state_next = S_NRD;
        end else if (st.out_free) begin
          cmd.nack_emit = 1'b1;
        end
      end
      S_DRD: begin
        if (st.done_end) begin
          state_next = S_DFIN;
        end else begin
          cmd.scan_rd = 1'b1;
          state_next = S_DWT;
        end
      end
      S_DWT: begin
        cmd.done_chk = 1'b1;
        if (st.word_full) begin
          cmd.ptr_inc = 1'b1;
          state_next = S_DRD;
        end else begin
          state_next = S_DFIN;
        end
      end
      S_DFIN: begin
        cmd.finish = 1'b1;
        state_next = S_STAT;
      end
      S_STAT: begin
        if (st.out_free) begin
          cmd.stat_emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_RCLR;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: hw/rtl/ncrt_dp.sv
// Datapath: packet checks, tracker state, chunk bitmap RAM, scans and result register.
`default_nettype none
module ncrt_dp #(
  parameter int CHUNK_CAPACITY = ncrt_pkg::CHUNK_CAPACITY_DEF,
  parameter int FILE_CAPACITY  = ncrt_pkg::FILE_CAPACITY_DEF,
  parameter int MAX_NACKS      = ncrt_pkg::MAX_NACKS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ncrt_pkg::ncrt_cmd_t cmd,
  output ncrt_pkg::ncrt_stat_t     st,
  input  wire logic [1:0]          in_cmd,
  input  wire logic [15:0]         in_file,
  input  wire logic [15:0]         in_chunk,
  input  wire logic [15:0]         in_total,
  input  wire logic                in_csok,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     out_kind,
  output logic [11:0]              out_chunk,
  output logic [7:0]               out_file,
  output logic [2:0]               out_outcome,
  output logic                     out_fc,
  output logic                     out_all,
  output logic                     out_last
);
  import ncrt_pkg::*;

  localparam int W     = (CHUNK_CAPACITY >= 64) ? 64 : 16;
  localparam int LW    = $clog2(W);
  localparam int DEPTH = (CHUNK_CAPACITY + W - 1) / W;
  localparam int DW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(CHUNK_CAPACITY);
  localparam int EW    = CW + 1;
  localparam int FW    = (FILE_CAPACITY > 1) ? $clog2(FILE_CAPACITY) : 1;
  localparam int NW    = $clog2(MAX_NACKS + 1);
  localparam int PW    = ((DW > FW) ? DW : FW) + 1;
  // reset sweep covers both the bitmap and the finished-file RAM
  localparam int RN    = (DEPTH > FILE_CAPACITY) ? DEPTH : FILE_CAPACITY;

  // tracker state
  logic [FW-1:0]            active_file;
  logic [EW-1:0]            expected_total;
  logic [CW-1:0]            highest_chunk;
  logic                     active_done;
  logic [15:0]              files_completed;
  logic [15:0]              files_expected;

  // captured header
  logic [1:0]    hdr_cmd;
  logic [15:0]   hdr_file;
  logic [15:0]   hdr_chunk;
  logic [15:0]   hdr_total;
  logic          hdr_csok;

  // per-item working registers
  logic [CW-1:0] seq_q;
  logic [2:0]    outcome_q;
  logic          fc_q;
  logic          proc_q;
  logic          done_q;
  logic [PW-1:0] ptr;
  logic [NW-1:0] nack_cnt;
  logic [W-1:0]  held;

  // finished-file RAM, read at accept with the incoming file id
  logic          ff_wr_en;
  logic [FW-1:0] ff_wr_addr;
  logic [0:0]    ff_wr_data, ff_rd_data;

  assign ff_wr_en      = cmd.fclr || (cmd.finish && done_q);
  assign ff_wr_addr    = cmd.fclr ? ptr[FW-1:0] : active_file;
  assign ff_wr_data[0] = !cmd.fclr;

  ncrt_ram #(.WIDTH(1), .DEPTH(FILE_CAPACITY), .AW(FW)) u_files (
    .clk     (clk),
    .wr_en   (ff_wr_en),
    .wr_addr (ff_wr_addr),
    .wr_data (ff_wr_data),
    .rd_en   (cmd.accept),
    .rd_addr (in_file[FW-1:0]),
    .rd_data (ff_rd_data)
  );

  // decision on the captured header
  logic          is_info, is_data, in_rng, fin, sw, redund;
  logic [FW-1:0] fid_lo;
  logic [EW-1:0] sat_tot;

  assign fid_lo  = hdr_file[FW-1:0];
  assign is_info = (hdr_cmd == CMD_INFO);
  assign is_data = (hdr_cmd == CMD_DATA);
  assign in_rng  = (17'(hdr_chunk) < 17'(CHUNK_CAPACITY)) &&
                   (17'(hdr_file) < 17'(FILE_CAPACITY));
  assign fin     = in_rng && ff_rd_data[0];
  assign sw      = (fid_lo != active_file);
  assign redund  = !sw && active_done;
  assign sat_tot = (17'(hdr_total) > 17'(CHUNK_CAPACITY)) ? EW'(CHUNK_CAPACITY) :
                   EW'(hdr_total);

  logic good_data;
  assign good_data = is_data && in_rng && !fin;

  assign st.dec_clear = good_data && sw;
  assign st.dec_proc  = good_data && !redund && hdr_csok;
  assign st.proc_q    = proc_q;
  assign st.clr_last  = (ptr[DW-1:0] == DW'(DEPTH - 1));
  assign st.rclr_last = (ptr == PW'(RN - 1));

  // bitmap RAM
  logic          wr_en, rd_en;
  logic [DW-1:0] wr_addr, rd_addr, seq_word;
  logic [W-1:0]  wr_data, rd_data, seq_bit;
  logic [LW-1:0] seq_lo;

  assign seq_lo   = seq_q[LW-1:0];
  assign seq_word = DW'(seq_q >> LW);
  assign seq_bit  = W'(1) << seq_lo;
  assign wr_en    = cmd.clr_wr || cmd.mark_wr;
  assign wr_addr  = cmd.mark_wr ? seq_word : ptr[DW-1:0];
  assign wr_data  = cmd.mark_wr ? (rd_data | seq_bit) : '0;
  assign rd_en    = cmd.mark_rd || cmd.scan_rd;
  assign rd_addr  = cmd.mark_rd ? seq_word : ptr[DW-1:0];

  ncrt_ram #(.WIDTH(W), .DEPTH(DEPTH), .AW(DW)) u_bitmap (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // valid-bit mask of the word at ptr against a chunk limit; also end-of-scan flag
  logic [17:0]   ptr_x, hi_word, ex_word;
  logic [LW-1:0] hi_bit, ex_bit;
  logic [W-1:0]  hi_mask, ex_mask;

  assign ptr_x   = 18'(ptr);
  assign hi_word = 18'(highest_chunk >> LW);
  assign hi_bit  = highest_chunk[LW-1:0];
  assign ex_word = 18'(expected_total >> LW);
  assign ex_bit  = expected_total[LW-1:0];

  always_comb begin
    if (ptr_x < hi_word) hi_mask = '1;
    else if (ptr_x == hi_word) hi_mask = (W'(1) << hi_bit) - W'(1);
    else hi_mask = '0;
    if (ptr_x < ex_word) ex_mask = '1;
    else if (ptr_x == ex_word) ex_mask = (W'(1) << ex_bit) - W'(1);
    else ex_mask = '0;
  end

  assign st.nack_end  = (nack_cnt == NW'(MAX_NACKS)) ||
                        !((ptr_x < hi_word) || ((ptr_x == hi_word) && (hi_bit != '0)));
  assign st.done_end  = !((ptr_x < ex_word) || ((ptr_x == ex_word) && (ex_bit != '0)));
  assign st.word_full = &(rd_data | ~ex_mask);
  assign st.word_done = (&held) || (nack_cnt == NW'(MAX_NACKS));

  // lowest missing chunk in the held word
  logic [LW-1:0] zero_idx;
  always_comb begin
    zero_idx = '0;
    for (int j = W - 1; j >= 0; j--) begin
      if (!held[j]) zero_idx = LW'(j);
    end
  end

  logic out_free;
  assign out_free    = !out_valid || out_ready;
  assign st.out_free = out_free;

  logic [CW-1:0] nack_idx;
  assign nack_idx = CW'({ptr, zero_idx});

  always_ff @(posedge clk) begin
    if (rst) begin
      active_file     <= '0;
      expected_total  <= '0;
      highest_chunk   <= '0;
      active_done     <= 1'b0;
      files_completed <= '0;
      files_expected  <= FILES_EXPECTED_RST;
      ptr             <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cmd.decide) begin
        if (is_info) files_expected <= hdr_file;
        if (good_data) begin
          if (sw) begin
            active_file   <= fid_lo;
            highest_chunk <= '0;
            active_done   <= 1'b0;
          end
          if (sw || !active_done) begin
            expected_total <= (sw || expected_total == '0) ? sat_tot : expected_total;
          end
        end
      end
      if (cmd.mark_wr && (seq_q > highest_chunk)) highest_chunk <= seq_q;
      if (cmd.finish) begin
        active_done <= done_q;
        if (done_q) begin
          if (files_completed != 16'hFFFF) files_completed <= files_completed + 16'd1;
        end
      end
      if (cmd.ptr_clr) ptr <= '0;
      else if (cmd.ptr_inc) ptr <= ptr + PW'(1);
      if (cmd.nack_emit || cmd.stat_emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      hdr_cmd   <= in_cmd;
      hdr_file  <= in_file;
      hdr_chunk <= in_chunk;
      hdr_total <= in_total;
      hdr_csok  <= in_csok;
      seq_q     <= in_chunk[CW-1:0];
    end
    if (cmd.decide) begin
      fc_q   <= 1'b0;
      proc_q <= good_data && !redund && hdr_csok;
      if (is_info) outcome_q <= OC_INFO;
      else if (!is_data) outcome_q <= OC_OTHER;
      else if (!in_rng) outcome_q <= OC_RANGE;
      else if (fin) outcome_q <= OC_FILE_DONE;
      else if (redund) outcome_q <= OC_REDUNDANT;
      else if (!hdr_csok) outcome_q <= OC_BAD_CSUM;
      else outcome_q <= OC_STORED;
    end
    if (cmd.mark_wr) outcome_q <= (|(rd_data & seq_bit)) ? OC_DUPLICATE : OC_STORED;
    if (cmd.ptr_clr) begin
      nack_cnt <= '0;
      done_q   <= 1'b1;
    end
    if (cmd.nack_load) held <= rd_data | ~hi_mask;
    if (cmd.nack_emit) begin
      held[zero_idx] <= 1'b1;
      nack_cnt       <= nack_cnt + NW'(1);
    end
    if (cmd.done_chk && !st.word_full) done_q <= 1'b0;
    if (cmd.finish) fc_q <= done_q;
    if (cmd.nack_emit) begin
      out_kind    <= KIND_NACK;
      out_chunk   <= 12'(nack_idx);
      out_file    <= 8'(16'(active_file));
      out_outcome <= OC_STORED;
      out_fc      <= 1'b0;
      out_all     <= 1'b0;
      out_last    <= 1'b0;
    end else if (cmd.stat_emit) begin
      out_kind    <= KIND_STATUS;
      out_chunk   <= '0;
      out_file    <= 8'(16'(active_file));
      out_outcome <= outcome_q;
      out_fc      <= fc_q;
      out_all     <= (files_completed >= files_expected);
      out_last    <= 1'b1;
    end
  end

endmodule
`default_nettype wire
